[sv/rbae_pkg.sv]
package rbae_pkg;

  localparam int ADDR_BITS  = 24;
  localparam int COORD_BITS = 12;
  localparam int PIXEL_BITS = 16;
  localparam int PITCH_BITS = COORD_BITS + 1;
  localparam int ROP_BITS   = 4;

  localparam int IN_FIELD_BITS  = ROP_BITS + 2 * PIXEL_BITS;
  localparam int IN_DATA_BITS   = (IN_FIELD_BITS + 7) / 8 * 8;
  localparam int OUT_FIELD_BITS = 3 * ADDR_BITS + PIXEL_BITS;
  localparam int OUT_DATA_BITS  = (OUT_FIELD_BITS + 7) / 8 * 8;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = PITCH_BITS;

  typedef logic [ADDR_BITS-1:0]  addr_t;
  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [PITCH_BITS-1:0] pitch_t;
  typedef logic [PIXEL_BITS-1:0] pixel_t;
  typedef logic [ROP_BITS-1:0]   rop_t;

  // register map
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_SOURCE_X     = 3'd0,
    REG_SOURCE_Y     = 3'd1,
    REG_TARGET_X     = 3'd2,
    REG_TARGET_Y     = 3'd3,
    REG_RECT_WIDTH   = 3'd4,
    REG_RECT_HEIGHT  = 3'd5,
    REG_SOURCE_PITCH = 3'd6,
    REG_TARGET_PITCH = 3'd7
  } cfg_reg_t;

  // transaction kind carried in tuser
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_PIXEL = 1'b1;

  // minterm select: bit 0 s&d, bit 1 s&~d, bit 2 ~s&d, bit 3 ~s&~d
  function automatic pixel_t apply_rop(input rop_t op, input pixel_t s, input pixel_t d);
    pixel_t v;
    v = ({PIXEL_BITS{op[0]}} & s & d)
      | ({PIXEL_BITS{op[1]}} & s & ~d)
      | ({PIXEL_BITS{op[2]}} & ~s & d)
      | ({PIXEL_BITS{op[3]}} & ~s & ~d);
    return v;
  endfunction

endpackage

[sv/rop_blit_address_engine_core.sv]
// Rectangle blitter address engine with 16 raster operations on pixel words. A start
// transaction (tuser 0) latches the raster operation, picks an overlap-safe walk order
// from the configured corners (bottom to top when the source lies above the destination,
// right to left on a shared top row with the source to the left, else row-major forward)
// and returns the fetch offsets of the first pixel; an empty rectangle returns tlast with
// zero offsets. Each pixel transaction (tuser 1) brings the source and old destination
// words read at the last given offsets and returns the destination write, the offsets to
// fetch next and tlast on the final pixel. The block takes one transaction per clock while
// the result stream is not stalled, and each result passes through the input register, then
// the result register; the longest path is the start offset, row times pitch plus column,
// one 13 by 13 bit multiply per side between the two registers. Configuration writes are
// always taken and must only happen while no blit result is outstanding.
module rop_blit_address_engine_core
  import rbae_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  // configuration write channel
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  // input stream
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [IN_DATA_BITS-1:0]   s_tdata,   // rop, source_pixel, old_target_pixel, zero pad
  input  logic                      s_tuser,   // func
  // result stream
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [OUT_DATA_BITS-1:0]  m_tdata,   // write_addr, write_value, fetch_source_addr,
                                               // fetch_target_addr
  output logic                      m_tuser,   // write_valid
  output logic                      m_tlast    // last
);

  // configuration registers
  coord_t source_x, source_y, target_x, target_y;
  coord_t rect_width, rect_height;
  pitch_t source_pitch, target_pitch;

  // blit walk state
  logic   busy, busy_next;
  rop_t   op_code, op_code_next;
  logic   walk_left, walk_left_next;
  logic   walk_up, walk_up_next;
  coord_t column_left, column_left_next;
  coord_t rows_left, rows_left_next;
  addr_t  source_cursor, source_cursor_next;
  addr_t  target_cursor, target_cursor_next;

  // input register
  logic   in_valid;
  logic   in_func;
  rop_t   in_rop;
  pixel_t in_source;
  pixel_t in_target;

  // result register payload
  logic   out_write_valid;
  addr_t  out_write_addr;
  pixel_t out_write_value;
  addr_t  out_fetch_source;
  addr_t  out_fetch_target;
  logic   out_last;

  logic   s_accept;
  logic   process;

  // start-time values
  logic   start_up, start_left, start_empty;
  pitch_t start_src_row, start_tgt_row;
  pitch_t start_src_col, start_tgt_col;
  addr_t  start_src_addr, start_tgt_addr;

  // row change values
  coord_t span;
  addr_t  src_row_base, tgt_row_base;
  addr_t  src_next_row, tgt_next_row;

  // combinational result
  logic   res_write_valid;
  addr_t  res_write_addr;
  pixel_t res_write_value;
  logic   res_last;

  // ---------------------------------------------------------------------------
  // configuration port, always ready; unknown indexes cannot occur in a 3-bit map
  // ---------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_x     <= '0;
      source_y     <= '0;
      target_x     <= '0;
      target_y     <= '0;
      rect_width   <= '0;
      rect_height  <= '0;
      source_pitch <= '0;
      target_pitch <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SOURCE_X:     source_x     <= cfg_data[COORD_BITS-1:0];
        REG_SOURCE_Y:     source_y     <= cfg_data[COORD_BITS-1:0];
        REG_TARGET_X:     target_x     <= cfg_data[COORD_BITS-1:0];
        REG_TARGET_Y:     target_y     <= cfg_data[COORD_BITS-1:0];
        REG_RECT_WIDTH:   rect_width   <= cfg_data[COORD_BITS-1:0];
        REG_RECT_HEIGHT:  rect_height  <= cfg_data[COORD_BITS-1:0];
        REG_SOURCE_PITCH: source_pitch <= cfg_data;
        REG_TARGET_PITCH: target_pitch <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // handshake: the input register drains whenever the result register is free
  // or being emptied in the same cycle
  // ---------------------------------------------------------------------------
  assign process  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || process;
  assign s_accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_accept) begin
      in_valid <= 1'b1;
    end else if (process) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      in_func   <= s_tuser;
      in_rop    <= s_tdata[ROP_BITS-1:0];
      in_source <= s_tdata[ROP_BITS +: PIXEL_BITS];
      in_target <= s_tdata[ROP_BITS+PIXEL_BITS +: PIXEL_BITS];
    end
  end

  // ---------------------------------------------------------------------------
  // start: walk direction and first pixel offsets
  // ---------------------------------------------------------------------------
  assign start_up    = source_y < target_y;
  assign start_left  = (source_y == target_y) && (source_x < target_x);
  assign start_empty = (rect_width == '0) || (rect_height == '0);

  // bottom row / right column when walking backward; only used with a nonempty rectangle
  assign start_src_row = start_up ? PITCH_BITS'(source_y) + PITCH_BITS'(rect_height) - 1'b1
                                  : PITCH_BITS'(source_y);
  assign start_tgt_row = start_up ? PITCH_BITS'(target_y) + PITCH_BITS'(rect_height) - 1'b1
                                  : PITCH_BITS'(target_y);
  assign start_src_col = start_left ? PITCH_BITS'(source_x) + PITCH_BITS'(rect_width) - 1'b1
                                    : PITCH_BITS'(source_x);
  assign start_tgt_col = start_left ? PITCH_BITS'(target_x) + PITCH_BITS'(rect_width) - 1'b1
                                    : PITCH_BITS'(target_x);

  // offsets wrap modulo the address width
  assign start_src_addr = ADDR_BITS'(start_src_row) * ADDR_BITS'(source_pitch)
                        + ADDR_BITS'(start_src_col);
  assign start_tgt_addr = ADDR_BITS'(start_tgt_row) * ADDR_BITS'(target_pitch)
                        + ADDR_BITS'(start_tgt_col);

  // ---------------------------------------------------------------------------
  // row change: undo the column walk, then one line up or down; width and
  // pitches are taken live here
  // ---------------------------------------------------------------------------
  assign span = rect_width - 1'b1;

  assign src_row_base = walk_left ? source_cursor + ADDR_BITS'(span)
                                  : source_cursor - ADDR_BITS'(span);
  assign tgt_row_base = walk_left ? target_cursor + ADDR_BITS'(span)
                                  : target_cursor - ADDR_BITS'(span);
  assign src_next_row = walk_up ? src_row_base - ADDR_BITS'(source_pitch)
                                : src_row_base + ADDR_BITS'(source_pitch);
  assign tgt_next_row = walk_up ? tgt_row_base - ADDR_BITS'(target_pitch)
                                : tgt_row_base + ADDR_BITS'(target_pitch);

  // ---------------------------------------------------------------------------
  // per-transaction state update and result
  // ---------------------------------------------------------------------------
  always_comb begin
    busy_next          = busy;
    op_code_next       = op_code;
    walk_left_next     = walk_left;
    walk_up_next       = walk_up;
    column_left_next   = column_left;
    rows_left_next     = rows_left;
    source_cursor_next = source_cursor;
    target_cursor_next = target_cursor;
    res_write_valid    = 1'b0;
    res_write_addr     = '0;
    res_write_value    = '0;
    res_last           = 1'b0;

    if (in_func == FUNC_START) begin
      // a start during a blit abandons it
      op_code_next   = in_rop;
      walk_up_next   = start_up;
      walk_left_next = start_left;
      if (start_empty) begin
        busy_next          = 1'b0;
        column_left_next   = '0;
        rows_left_next     = '0;
        source_cursor_next = '0;
        target_cursor_next = '0;
        res_last           = 1'b1;
      end else begin
        busy_next          = 1'b1;
        column_left_next   = rect_width - 1'b1;
        rows_left_next     = rect_height - 1'b1;
        source_cursor_next = start_src_addr;
        target_cursor_next = start_tgt_addr;
      end
    end else if (busy) begin
      res_write_valid = 1'b1;
      res_write_addr  = target_cursor;
      res_write_value = apply_rop(op_code, in_source, in_target);
      if (column_left != '0) begin
        column_left_next = column_left - 1'b1;
        if (walk_left) begin
          source_cursor_next = source_cursor - 1'b1;
          target_cursor_next = target_cursor - 1'b1;
        end else begin
          source_cursor_next = source_cursor + 1'b1;
          target_cursor_next = target_cursor + 1'b1;
        end
      end else if (rows_left != '0) begin
        rows_left_next     = rows_left - 1'b1;
        column_left_next   = span;
        source_cursor_next = src_next_row;
        target_cursor_next = tgt_next_row;
      end else begin
        // final pixel: fetch offsets repeat, block goes idle
        busy_next = 1'b0;
        res_last  = 1'b1;
      end
    end
    // a pixel transaction while idle is dropped and reports the cursors
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      op_code       <= '0;
      walk_left     <= 1'b0;
      walk_up       <= 1'b0;
      column_left   <= '0;
      rows_left     <= '0;
      source_cursor <= '0;
      target_cursor <= '0;
    end else if (process) begin
      busy          <= busy_next;
      op_code       <= op_code_next;
      walk_left     <= walk_left_next;
      walk_up       <= walk_up_next;
      column_left   <= column_left_next;
      rows_left     <= rows_left_next;
      source_cursor <= source_cursor_next;
      target_cursor <= target_cursor_next;
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (process) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      out_write_valid  <= res_write_valid;
      out_write_addr   <= res_write_addr;
      out_write_value  <= res_write_value;
      out_fetch_source <= source_cursor_next;
      out_fetch_target <= target_cursor_next;
      out_last         <= res_last;
    end
  end

  assign m_tdata = OUT_DATA_BITS'({out_fetch_target, out_fetch_source,
                                   out_write_value, out_write_addr});
  assign m_tuser = out_write_valid;
  assign m_tlast = out_last;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------

  // results without a write carry a zero address and value
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> out_write_addr == '0 && out_write_value == '0)
    else $error("non-write result carries write payload");

  // a blit only ends through a processed transaction
  assert property (@(posedge clk) disable iff (rst)
    $fell(busy) && !$past(rst) |-> $past(process))
    else $error("blit ended without a transaction");

  // a pending last result means the walk is idle
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> !busy)
    else $error("last result shown while blit still busy");

  // a write result is only produced from a pixel transaction
  assert property (@(posedge clk) disable iff (rst)
    process && res_write_valid |-> in_func == FUNC_PIXEL && busy)
    else $error("write produced outside an active blit");

endmodule
